>>> hdl/retry_concurrency_admission_unit_assert.svh
// Assertion macros for the retry admission unit checker.
`ifndef RETRY_CONCURRENCY_ADMISSION_UNIT_ASSERT_SVH
`define RETRY_CONCURRENCY_ADMISSION_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define RCA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rca checker: implication failed");

// Consequence expected in the cycle after the antecedent.
`define RCA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rca checker: next-cycle check failed");

// Plain expression checked on every clock edge, reset included.
`define RCA_ASSERT_ALW(lbl, clk, expr) \
  lbl: assert property (@(posedge clk) (expr)) \
    else $error("rca checker: invariant failed");

`endif

>>> hdl/rca_pkg.sv
// Shared types, constants and helper functions of the retry admission unit.
package rca_pkg;

  localparam int STREAMS      = 16;
  localparam int MAX_ATTEMPTS = 16;
  localparam int SID_W        = $clog2(STREAMS);
  localparam int ATT_W        = $clog2(MAX_ATTEMPTS);

  localparam int CNT_W    = 16;
  localparam int SCNT_W   = 8;
  localparam int BUDGET_W = 14;
  localparam int PROD_W   = CNT_W + BUDGET_W;   // tries * budget
  localparam int LIM_W    = 17;                 // floor(prod / 10000) fits here

  // floor(p / 10000) ~ (p * RECIP) >> RECIP_SHIFT, short by at most one
  localparam int              RECIP_SHIFT = 30;
  localparam logic [LIM_W-1:0] RECIP      = 17'd107374;
  localparam logic [PROD_W-1:0] DIVISOR   = 30'd10000;

  // Event kinds
  localparam logic [2:0] KIND_TRY_START  = 3'd0;
  localparam logic [2:0] KIND_TRY_OK     = 3'd1;
  localparam logic [2:0] KIND_OK_DONE    = 3'd2;
  localparam logic [2:0] KIND_TRY_ABORT  = 3'd3;
  localparam logic [2:0] KIND_ADMIT      = 3'd4;

  // Register indexes
  localparam logic CFG_BUDGET = 1'b0;
  localparam logic CFG_MIN    = 1'b1;

  localparam logic [BUDGET_W-1:0] BUDGET_RST = 14'd2000;
  localparam logic [CNT_W-1:0]    MIN_RST    = 16'd3;

  typedef struct packed {
    logic capture;
    logic mul;
    logic recip;
    logic corr;
    logic apply;
  } rca_cmd_t;

  typedef struct packed {
    logic admit_req;
  } rca_status_t;

  function automatic logic [CNT_W-1:0] inc_sat16(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] dec_sat16(input logic [CNT_W-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

  function automatic logic [SCNT_W-1:0] inc_sat8(input logic [SCNT_W-1:0] v);
    return (v == {SCNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [SCNT_W-1:0] dec_sat8(input logic [SCNT_W-1:0] v);
    return (v == '0) ? v : v - 1'b1;
  endfunction

endpackage

>>> hdl/retry_concurrency_admission_unit.sv
// Top level of the retry concurrency admission unit.
//
//  channel  | handshake          | fields
//  ---------+--------------------+------------------------------------------------
//  event in | start & !busy      | kind, stream_id, attempt, prev_attempt,
//           |                    | abort_previous
//  result   | done (one cycle)   | admitted, remaining_retries, retry_circuit_open,
//           |                    | total_active_tries, total_active_retries,
//           |                    | stream_tries
//  config   | wr_en              | wr_index, wr_data
//
// Sequence: an admit request runs a limit pass, then the update, then a limit
// pass; any other kind runs the update and then a limit pass. The limit unit
// (multiply, reciprocal multiply, correction) runs once for the pre-event
// limit of an admit request and once for the post-event limit of every word.
// A new word may be accepted in the done cycle of the previous one.
// Reset (rst, synchronous) clears all counters and bitmaps and restores the
// register defaults; no clearing sweep is needed. Results cannot be stalled.
module retry_concurrency_admission_unit (
  input  logic        clk,
  input  logic        rst,
  // event word
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [3:0]  stream_id,
  input  logic [3:0]  attempt,
  input  logic [3:0]  prev_attempt,
  input  logic        abort_previous,
  // result word
  output logic        done,
  output logic        admitted,
  output logic [15:0] remaining_retries,
  output logic        retry_circuit_open,
  output logic [15:0] total_active_tries,
  output logic [15:0] total_active_retries,
  output logic [7:0]  stream_tries,
  // config writes
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [15:0] wr_data
);

  rca_pkg::rca_cmd_t    cmd;
  rca_pkg::rca_status_t status;

  // sequencer: decides which limit passes a word needs
  rca_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // counters, bitmaps and arithmetic
  rca_datapath u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .status               (status),
    .wr_en                (wr_en),
    .wr_index             (wr_index),
    .wr_data              (wr_data),
    .kind                 (kind),
    .stream_id            (stream_id),
    .attempt              (attempt),
    .prev_attempt         (prev_attempt),
    .abort_previous       (abort_previous),
    .admitted             (admitted),
    .remaining_retries    (remaining_retries),
    .retry_circuit_open   (retry_circuit_open),
    .total_active_tries   (total_active_tries),
    .total_active_retries (total_active_retries),
    .stream_tries         (stream_tries)
  );

endmodule

>>> hdl/rca_ctrl.sv
// Sequencing state machine of the retry admission unit.
module rca_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  rca_pkg::rca_status_t status,
  output rca_pkg::rca_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_RECIP = 3'd2;
  localparam logic [2:0] S_CORR  = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state, state_next;
  logic       phase, phase_next;   // 1: limit pass after the update
  logic       accept;

  assign busy   = (state != S_IDLE) && (state != S_DONE);
  assign done   = (state == S_DONE);
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    phase_next = phase;
    unique case (state) inside
      S_IDLE, S_DONE: begin
        if (accept) begin
          phase_next = 1'b0;
          state_next = status.admit_req ? S_MUL : S_APPLY;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MUL:   state_next = S_RECIP;
      S_RECIP: state_next = S_CORR;
      S_CORR:  state_next = phase ? S_DONE : S_APPLY;
      S_APPLY: begin
        phase_next = 1'b1;
        state_next = S_MUL;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.capture = accept;
    cmd.mul     = (state == S_MUL);
    cmd.recip   = (state == S_RECIP);
    cmd.corr    = (state == S_CORR);
    cmd.apply   = (state == S_APPLY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule

>>> hdl/rca_datapath.sv
// Counters, retry bitmaps, config registers and limit arithmetic.
module rca_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  rca_pkg::rca_cmd_t    cmd,
  output rca_pkg::rca_status_t status,
  input  logic                 wr_en,
  input  logic                 wr_index,
  input  logic [15:0]          wr_data,
  input  logic [2:0]           kind,
  input  logic [3:0]           stream_id,
  input  logic [3:0]           attempt,
  input  logic [3:0]           prev_attempt,
  input  logic                 abort_previous,
  output logic                 admitted,
  output logic [15:0]          remaining_retries,
  output logic                 retry_circuit_open,
  output logic [15:0]          total_active_tries,
  output logic [15:0]          total_active_retries,
  output logic [7:0]           stream_tries
);

  // config
  logic [rca_pkg::BUDGET_W-1:0] budget;
  logic [rca_pkg::CNT_W-1:0]    min_limit;

  // state
  logic [rca_pkg::CNT_W-1:0]        tries, retries;
  logic [rca_pkg::SCNT_W-1:0]       stc [rca_pkg::STREAMS];
  logic [rca_pkg::MAX_ATTEMPTS-1:0] bmp [rca_pkg::STREAMS];

  // captured word
  logic [2:0]                k_r;
  logic [rca_pkg::SID_W-1:0] sid_r;
  logic [rca_pkg::ATT_W-1:0] att_r, prev_r;
  logic                      abort_r;

  // limit pipeline
  logic [rca_pkg::PROD_W-1:0] prod;
  logic [rca_pkg::LIM_W-1:0]  q_est, lim;
  logic                       adm_r;
  logic [rca_pkg::SCNT_W-1:0] stries_r;

  assign status.admit_req = (kind == rca_pkg::KIND_ADMIT);

  // ---- limit arithmetic ----
  logic [rca_pkg::PROD_W+rca_pkg::LIM_W-1:0] recip_prod;
  logic [rca_pkg::PROD_W-1:0]                q_back, resid;
  logic [rca_pkg::LIM_W-1:0]                 q_fix, lim_next;

  assign recip_prod = (rca_pkg::PROD_W+rca_pkg::LIM_W)'(prod)
                    * (rca_pkg::PROD_W+rca_pkg::LIM_W)'(rca_pkg::RECIP);
  assign q_back     = rca_pkg::PROD_W'(q_est) * rca_pkg::DIVISOR;
  assign resid      = prod - q_back;
  assign q_fix      = (resid >= rca_pkg::DIVISOR) ? q_est + 1'b1 : q_est;
  assign lim_next   = (q_fix > rca_pkg::LIM_W'(min_limit)) ? q_fix
                                                          : rca_pkg::LIM_W'(min_limit);

  always_ff @(posedge clk) begin
    if (cmd.mul)
      prod <= rca_pkg::PROD_W'(tries) * rca_pkg::PROD_W'(budget);
    if (cmd.recip)
      q_est <= recip_prod[rca_pkg::PROD_W+rca_pkg::LIM_W-1 -: rca_pkg::LIM_W];
    if (cmd.corr)
      lim <= lim_next;
  end

  // ---- event update ----
  logic [rca_pkg::MAX_ATTEMPTS-1:0] cur_map, map_n;
  logic [rca_pkg::SCNT_W-1:0]       cur_st, st_n;
  logic [rca_pkg::CNT_W-1:0]        tries_n, retries_n;
  logic                             bit_att, bit_prev, delta, fits, adm_n;

  assign cur_map  = bmp[sid_r];
  assign cur_st   = stc[sid_r];
  assign bit_att  = cur_map[att_r];
  assign bit_prev = cur_map[prev_r];
  assign delta    = !(abort_r && bit_prev);
  assign fits     = (rca_pkg::LIM_W'(retries) + rca_pkg::LIM_W'(delta)) <= lim;

  always_comb begin
    map_n     = cur_map;
    st_n      = cur_st;
    tries_n   = tries;
    retries_n = retries;
    adm_n     = 1'b0;
    unique case (k_r)
      rca_pkg::KIND_TRY_START: begin
        if (!bit_att) begin
          tries_n = rca_pkg::inc_sat16(tries);
          st_n    = rca_pkg::inc_sat8(cur_st);
        end
      end
      rca_pkg::KIND_TRY_OK: begin
        if (bit_att) begin
          map_n[att_r] = 1'b0;
          retries_n    = rca_pkg::dec_sat16(retries);
        end
      end
      rca_pkg::KIND_OK_DONE: begin
        tries_n = rca_pkg::dec_sat16(tries);
        st_n    = rca_pkg::dec_sat8(cur_st);
      end
      rca_pkg::KIND_TRY_ABORT: begin
        if (bit_att) begin
          map_n[att_r] = 1'b0;
          retries_n    = rca_pkg::dec_sat16(retries);
        end
        tries_n = rca_pkg::dec_sat16(tries);
        st_n    = rca_pkg::dec_sat8(cur_st);
      end
      rca_pkg::KIND_ADMIT: begin
        if (fits) begin
          adm_n = 1'b1;
          if (delta)
            retries_n = rca_pkg::inc_sat16(retries);
          if (abort_r) begin
            map_n[prev_r] = 1'b0;
          end else begin
            tries_n = rca_pkg::inc_sat16(tries);
            st_n    = rca_pkg::inc_sat8(cur_st);
          end
          map_n[att_r] = 1'b1;
        end
      end
      default: ;   // unused kinds leave state alone
    endcase
  end

  // captured word and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      k_r     <= kind;
      sid_r   <= stream_id;
      att_r   <= attempt;
      prev_r  <= prev_attempt;
      abort_r <= abort_previous;
    end
    if (cmd.apply) begin
      adm_r    <= adm_n;
      stries_r <= st_n;
    end
  end

  // control state and config
  always_ff @(posedge clk) begin
    if (rst) begin
      budget    <= rca_pkg::BUDGET_RST;
      min_limit <= rca_pkg::MIN_RST;
      tries     <= '0;
      retries   <= '0;
      for (int i = 0; i < rca_pkg::STREAMS; i++) begin
        stc[i] <= '0;
        bmp[i] <= '0;
      end
    end else begin
      if (wr_en) begin
        case (wr_index)
          rca_pkg::CFG_BUDGET: budget    <= wr_data[rca_pkg::BUDGET_W-1:0];
          rca_pkg::CFG_MIN:    min_limit <= wr_data;
          default: ;
        endcase
      end
      if (cmd.apply) begin
        tries      <= tries_n;
        retries    <= retries_n;
        stc[sid_r] <= st_n;
        bmp[sid_r] <= map_n;
      end
    end
  end

  // ---- result fields ----
  logic [rca_pkg::LIM_W-1:0] headroom;

  assign headroom = (lim >= rca_pkg::LIM_W'(retries)) ? lim - rca_pkg::LIM_W'(retries) : '0;

  assign remaining_retries    = headroom[rca_pkg::LIM_W-1] ? {rca_pkg::CNT_W{1'b1}}
                                                           : headroom[rca_pkg::CNT_W-1:0];
  assign retry_circuit_open   = (remaining_retries == '0);
  assign admitted             = adm_r;
  assign total_active_tries   = tries;
  assign total_active_retries = retries;
  assign stream_tries         = stries_r;

endmodule

>>> hdl/rca_checker.sv
// Port-level checker for the retry admission unit, bound to the top level.
`include "retry_concurrency_admission_unit_assert.svh"

module rca_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [15:0] remaining_retries,
  input logic        retry_circuit_open
);

  // an accepted word keeps the unit busy
  `RCA_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy && !done)
  // a result lasts one cycle
  `RCA_ASSERT_NXT(a_done_pulse, clk, rst, done, !done)
  // open flag tracks the remaining budget
  `RCA_ASSERT_IMP(a_open_flag, clk, rst, done, retry_circuit_open == (remaining_retries == 16'd0))
  // reset leaves the unit idle
  `RCA_ASSERT_ALW(a_reset_idle, clk, ($past(rst) !== 1'b1) || (!busy && !done))

endmodule

bind retry_concurrency_admission_unit rca_checker u_rca_checker (.*);
